// ===== rtl/sha1c_pkg.sv =====
// sha1c_pkg: shared types and constants for the SHA-1 engine.
// Used by sha1c_ctrl, sha1c_dp and sha1_hash_engine_core; no dependencies.
`default_nettype none
package sha1c_pkg;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [2:0] LAST_IDX   = 3'd4;

  // source of the byte shifted into the block buffer
  typedef enum logic [1:0] {
    BSEL_IN   = 2'd0,
    BSEL_PAD  = 2'd1,
    BSEL_ZERO = 2'd2,
    BSEL_LEN  = 2'd3
  } bsel_t;

  typedef struct packed {
    logic       push;        // shift one byte into the block buffer
    bsel_t      bsel;
    logic       count_byte;  // message byte: bump the bit count
    logic       len_load;    // latch final bit count for the length field
    logic       wv_load;     // load a..e from the chaining words
    logic       round_step;  // one compression round
    logic       chain_add;   // fold a..e into the chaining words
    logic       msg_done;    // digest taken: back to initial state
    logic [2:0] word_sel;    // digest word on the output
  } cmd_t;

  typedef struct packed {
    logic [5:0] pos;         // byte position within the current block
    logic       round_last;
  } stat_t;

endpackage
`default_nettype wire

// ===== rtl/sha1c_dp.sv =====
// sha1c_dp: SHA-1 datapath - block buffer / schedule window, round logic,
// chaining words and bit count. Depends on sha1c_pkg.
`default_nettype none
module sha1c_dp (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire sha1c_pkg::cmd_t cmd,
  input  wire logic [7:0]      in_byte,
  output sha1c_pkg::stat_t     stat,
  output logic [31:0]          digest_word
);

  logic [5:0]  pos_r;
  logic [63:0] bc_r;
  logic [63:0] len_r;
  logic [6:0]  rnd_r;
  // 16 words, word 0 in the top bits; bytes and schedule words enter at the bottom
  logic [511:0] win_r;
  logic [31:0] wv_r    [5];
  logic [31:0] chain_r [5];

  logic [7:0]  byte_mux;
  logic [31:0] w_t;
  logic [31:0] x_t;
  logic [31:0] f_t;
  logic [31:0] k_t;
  logic [31:0] tmp_t;

  always_comb begin
    case (cmd.bsel)
      sha1c_pkg::BSEL_IN:   byte_mux = in_byte;
      sha1c_pkg::BSEL_PAD:  byte_mux = sha1c_pkg::PAD_BYTE;
      sha1c_pkg::BSEL_ZERO: byte_mux = 8'h00;
      sha1c_pkg::BSEL_LEN:  byte_mux = len_r[63:56];
      default:              byte_mux = 8'h00;
    endcase
  end

  // window holds W[t-16..t-1]; for the first 16 rounds it rotates the message words
  assign x_t = win_r[95:64] ^ win_r[255:224] ^ win_r[447:416] ^ win_r[511:480];
  assign w_t = (rnd_r < 7'd16) ? win_r[511:480] : {x_t[30:0], x_t[31]};

  always_comb begin
    if (rnd_r < 7'd20) begin
      f_t = (wv_r[1] & wv_r[2]) | (~wv_r[1] & wv_r[3]);
      k_t = sha1c_pkg::K0;
    end else if (rnd_r < 7'd40) begin
      f_t = wv_r[1] ^ wv_r[2] ^ wv_r[3];
      k_t = sha1c_pkg::K1;
    end else if (rnd_r < 7'd60) begin
      f_t = (wv_r[1] & wv_r[2]) | (wv_r[1] & wv_r[3]) | (wv_r[2] & wv_r[3]);
      k_t = sha1c_pkg::K2;
    end else begin
      f_t = wv_r[1] ^ wv_r[2] ^ wv_r[3];
      k_t = sha1c_pkg::K3;
    end
  end

  assign tmp_t = {wv_r[0][26:0], wv_r[0][31:27]} + f_t + wv_r[4] + k_t + w_t;

  // control state: position, bit count, round index, chaining words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      bc_r       <= '0;
      rnd_r      <= '0;
      chain_r[0] <= sha1c_pkg::IV0;
      chain_r[1] <= sha1c_pkg::IV1;
      chain_r[2] <= sha1c_pkg::IV2;
      chain_r[3] <= sha1c_pkg::IV3;
      chain_r[4] <= sha1c_pkg::IV4;
    end else begin
      if (cmd.push) begin
        pos_r <= pos_r + 6'd1;
      end
      if (cmd.msg_done) begin
        bc_r <= '0;
      end else if (cmd.count_byte) begin
        bc_r <= bc_r + 64'd8;
      end
      if (cmd.wv_load) begin
        rnd_r <= '0;
      end else if (cmd.round_step) begin
        rnd_r <= rnd_r + 7'd1;
      end
      if (cmd.msg_done) begin
        chain_r[0] <= sha1c_pkg::IV0;
        chain_r[1] <= sha1c_pkg::IV1;
        chain_r[2] <= sha1c_pkg::IV2;
        chain_r[3] <= sha1c_pkg::IV3;
        chain_r[4] <= sha1c_pkg::IV4;
      end else if (cmd.chain_add) begin
        for (int i = 0; i < 5; i++) begin
          chain_r[i] <= chain_r[i] + wv_r[i];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      win_r <= {win_r[503:0], byte_mux};
    end else if (cmd.round_step) begin
      win_r <= {win_r[479:0], w_t};
    end
    if (cmd.len_load) begin
      len_r <= bc_r;
    end else if (cmd.push && cmd.bsel == sha1c_pkg::BSEL_LEN) begin
      len_r <= {len_r[55:0], 8'h00};
    end
    if (cmd.wv_load) begin
      for (int i = 0; i < 5; i++) begin
        wv_r[i] <= chain_r[i];
      end
    end else if (cmd.round_step) begin
      wv_r[0] <= tmp_t;
      wv_r[1] <= wv_r[0];
      wv_r[2] <= {wv_r[1][1:0], wv_r[1][31:2]};
      wv_r[3] <= wv_r[2];
      wv_r[4] <= wv_r[3];
    end
  end

  always_comb begin
    case (cmd.word_sel)
      3'd0:    digest_word = chain_r[0];
      3'd1:    digest_word = chain_r[1];
      3'd2:    digest_word = chain_r[2];
      3'd3:    digest_word = chain_r[3];
      3'd4:    digest_word = chain_r[4];
      default: digest_word = chain_r[0];
    endcase
  end

  assign stat.pos        = pos_r;
  assign stat.round_last = (rnd_r == sha1c_pkg::LAST_ROUND);

endmodule
`default_nettype wire

// ===== rtl/sha1c_ctrl.sv =====
// sha1c_ctrl: SHA-1 controller - input handshake, padding sequence,
// compression sequencing and digest output. Depends on sha1c_pkg.
`default_nettype none
module sha1c_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_byte_valid,
  input  wire logic             in_last_item,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [2:0]            out_word_index,
  output logic                  out_last_word,
  input  wire sha1c_pkg::stat_t stat,
  output sha1c_pkg::cmd_t       cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PAD80 = 8'b0000_0010,
    S_PADZ  = 8'b0000_0100,
    S_LEN   = 8'b0000_1000,
    S_CINIT = 8'b0001_0000,
    S_CRND  = 8'b0010_0000,
    S_CFIN  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t     state_r, state_nxt;
  state_t     ret_r, ret_nxt;   // where to resume after a compression
  logic [2:0] idx_r, idx_nxt;

  logic blk_full;
  assign blk_full = (stat.pos == sha1c_pkg::LAST_POS);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.word_sel = idx_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_byte_valid) begin
            cmd.push       = 1'b1;
            cmd.bsel       = sha1c_pkg::BSEL_IN;
            cmd.count_byte = 1'b1;
            if (blk_full) begin
              state_nxt = S_CINIT;
              ret_nxt   = in_last_item ? S_PAD80 : S_IDLE;
            end else if (in_last_item) begin
              state_nxt = S_PAD80;
            end
          end else if (in_last_item) begin
            state_nxt = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        cmd.push     = 1'b1;
        cmd.bsel     = sha1c_pkg::BSEL_PAD;
        cmd.len_load = 1'b1;
        if (blk_full) begin
          state_nxt = S_CINIT;
          ret_nxt   = S_PADZ;
        end else begin
          state_nxt = S_PADZ;
        end
      end
      S_PADZ: begin
        if (stat.pos == sha1c_pkg::LEN_POS) begin
          state_nxt = S_LEN;
        end else begin
          cmd.push = 1'b1;
          cmd.bsel = sha1c_pkg::BSEL_ZERO;
          if (blk_full) begin
            state_nxt = S_CINIT;
            ret_nxt   = S_PADZ;
          end
        end
      end
      S_LEN: begin
        cmd.push = 1'b1;
        cmd.bsel = sha1c_pkg::BSEL_LEN;
        if (blk_full) begin
          state_nxt = S_CINIT;
          ret_nxt   = S_OUT;
        end
      end
      S_CINIT: begin
        cmd.wv_load = 1'b1;
        state_nxt   = S_CRND;
      end
      S_CRND: begin
        cmd.round_step = 1'b1;
        if (stat.round_last) begin
          state_nxt = S_CFIN;
        end
      end
      S_CFIN: begin
        cmd.chain_add = 1'b1;
        state_nxt     = ret_r;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (idx_r == sha1c_pkg::LAST_IDX) begin
            cmd.msg_done = 1'b1;
            idx_nxt      = '0;
            state_nxt    = S_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = (state_r == S_OUT);
  assign out_word_index = idx_r;
  assign out_last_word  = (idx_r == sha1c_pkg::LAST_IDX);

endmodule
`default_nettype wire

// ===== rtl/sha1_hash_engine_core.sv =====
// SHA-1 engine, one message byte per word. A word that neither fills a block
// nor closes the message leaves the engine idle; a word completing a 64-byte
// block starts a compression (load, 80 rounds, fold) on the single round unit.
// After the last word: padding is shifted in, with one or two compressions,
// then five digest words (one a cycle when not stalled).
// Synchronous active-low reset loads the initial chaining words, clears counts.
`default_nettype none
module sha1_hash_engine_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_valid,
  input  wire logic        in_last_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);

  sha1c_pkg::cmd_t  cmd;
  sha1c_pkg::stat_t stat;

  sha1c_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte_valid  (in_byte_valid),
    .in_last_item   (in_last_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word_index (out_word_index),
    .out_last_word  (out_last_word),
    .stat           (stat),
    .cmd            (cmd)
  );

  sha1c_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_byte     (in_data_byte),
    .stat        (stat),
    .digest_word (out_digest_word)
  );

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking bench for sha1_hash_engine_core: message bytes in, digest words out.
// A local SHA-1 predictor queues each message's five words; uses sha1c_pkg and the RTL.
`timescale 1ns / 1ps
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        is_last;
  } digest_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_byte_valid;
  logic        in_last_item;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  // predictor state
  logic [31:0] hash_state [5];
  logic [7:0]  block_bytes [64];
  logic [63:0] msg_bit_len;
  digest_word_t digest_due[$];

  int send_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_rx = 1'b0;
  int mismatch_count = 0;
  int cycle_count = 0;

  sha1_hash_engine_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_byte_valid   (in_byte_valid),
    .in_last_item    (in_last_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void sha1_restart();
    hash_state[0] = sha1c_pkg::IV0;
    hash_state[1] = sha1c_pkg::IV1;
    hash_state[2] = sha1c_pkg::IV2;
    hash_state[3] = sha1c_pkg::IV3;
    hash_state[4] = sha1c_pkg::IV4;
    msg_bit_len = '0;
  endfunction

  function automatic void sha1_compress();
    logic [31:0] sched [16];
    logic [31:0] a, b, c, d, e, f, k, w, x, sum;
    int t;
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (t = 0; t < 80; t++) begin
      if (t < 16) begin
        w = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
      end else begin
        x = sched[(t+13) & 15] ^ sched[(t+8) & 15] ^ sched[(t+2) & 15] ^ sched[t & 15];
        w = {x[30:0], x[31]};
      end
      sched[t & 15] = w;
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = sha1c_pkg::K0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = sha1c_pkg::K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1c_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1c_pkg::K3;
      end
      sum = {a[26:0], a[31:27]} + f + e + k + w;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = sum;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
  endfunction

  // takes one accepted word; on the closing word pads and queues the digest
  function automatic void sha1_absorb(input logic [7:0] data, input logic has_byte,
                                      input logic closes);
    int pos;
    int i;
    logic [63:0] len;
    if (has_byte) begin
      pos = int'(msg_bit_len[8:3]);
      block_bytes[pos] = data;
      msg_bit_len += 64'd8;
      if (pos == 63) sha1_compress();
    end
    if (!closes) return;
    len = msg_bit_len;
    pos = int'(len[8:3]);
    block_bytes[pos] = sha1c_pkg::PAD_BYTE;
    for (i = pos + 1; i < 64; i++) block_bytes[i] = 8'h00;
    if (pos >= 56) begin
      sha1_compress();
      for (i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    end
    for (i = 0; i < 8; i++) block_bytes[63-i] = len[8*i +: 8];
    sha1_compress();
    for (i = 0; i < 5; i++) begin
      digest_due.push_back('{word: hash_state[i], idx: 3'(i), is_last: (i == 4)});
    end
    sha1_restart();
  endfunction

  function automatic void flag_error(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, what);
  endfunction

  // receiver: random stall, forced high while hold_rx is set
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= hold_rx || ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin : digest_check
    digest_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_due.size() == 0) begin
        flag_error($sformatf("unexpected digest word %h idx %0d last %b",
                             out_digest_word, out_word_index, out_last_word));
      end else begin
        want = digest_due.pop_front();
        if (out_digest_word !== want.word || out_word_index !== want.idx ||
            out_last_word !== want.is_last) begin
          flag_error($sformatf("digest word: exp %h/%0d/%b got %h/%0d/%b",
                               want.word, want.idx, want.is_last,
                               out_digest_word, out_word_index, out_last_word));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // entered and left at a falling edge
  task automatic send_word(input logic [7:0] data, input logic has_byte, input logic closes);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= data;
    in_byte_valid <= has_byte;
    in_last_item  <= closes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sha1_absorb(data, has_byte, closes);
    @(negedge clk);
  endtask

  // random bytes, stray empty words, and the closing word with or without a byte
  task automatic send_message(input int len);
    int n;
    logic tail_byte;
    tail_byte = (len > 0) && ($urandom_range(1) == 1);
    for (n = 0; n < len; n++) begin
      if ($urandom_range(9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      if (tail_byte && n == len - 1) send_word(8'($urandom), 1'b1, 1'b1);
      else send_word(8'($urandom), 1'b1, 1'b0);
    end
    if (!tail_byte) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic directed_cases();
    send_word(8'h00, 1'b0, 1'b1);   // empty message
    send_word(8'hFF, 1'b0, 1'b0);   // no byte, not closing: ignored
    send_word(8'h61, 1'b1, 1'b0);   // "abc", closing word carries the byte
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'hA5, 1'b0, 1'b1);   // data ignored on a byteless close
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'h80, 1'b1, 1'b0);
    send_word(8'h3C, 1'b0, 1'b0);
    send_word(8'h7F, 1'b1, 1'b0);
    send_word(8'h01, 1'b0, 1'b1);
  endtask

  // two lengths a byte apart, either side of a padding boundary: padding that just
  // fits then spills, or a pad byte in the last slot then a fresh padding block
  task automatic block_boundaries(input int tx_pct, input int rx_pct, input int fit_len);
    send_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    send_message(fit_len);
    send_message(fit_len + 1);
  endtask

  task automatic random_traffic(input int tx_pct, input int rx_pct, input int n_items);
    int sent;
    int len;
    send_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(2))
        0: len = $urandom_range(8);
        1: len = $urandom_range(66, 53);
        default: len = $urandom_range(140);
      endcase
      send_message(len);
      sent += len + 1;
    end
  endtask

  // digest side blocked for a long stretch while words keep coming
  task automatic stalled_output();
    send_idle_pct = 0;
    rx_stall_pct = 0;
    fork
      begin
        @(posedge clk);
        hold_rx = 1'b1;
        repeat (600) @(posedge clk);
        hold_rx = 1'b0;
      end
      repeat (3) send_message($urandom_range(6, 1));
    join
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data_byte  <= 8'h00;
    in_byte_valid <= 1'b0;
    in_last_item  <= 1'b0;
    sha1_restart();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    block_boundaries(16, 62, 55);
    directed_cases();
    block_boundaries(62, 16, 63);
    random_traffic(0, 0, 25);
    stalled_output();

    in_valid <= 1'b0;
    rx_stall_pct = 0;
    while (digest_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sha1c_pkg.sv
rtl/sha1c_dp.sv
rtl/sha1c_ctrl.sv
rtl/sha1_hash_engine_core.sv
test/testbench.sv
